[src/ctm_pkg.sv]
// ---------------------------------------------------------------------------
// ctm_pkg
// Shared types and constants of the command token matcher: transaction
// payloads, result status codes, and the controller/datapath interface.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ctm_pkg;

   localparam int MAX_DEFS    = 8;
   localparam int MAX_TOKEN   = 8;
   localparam int PAYLOAD_MAX = 16;

   localparam int SLOT_W  = $clog2(MAX_DEFS);
   localparam int SCAN_W  = $clog2(MAX_DEFS + 1);
   localparam int LEN_W   = 4;
   localparam int PAY_W   = 5;
   localparam int IDX_W   = $clog2(PAYLOAD_MAX);
   localparam int ACT_W   = 4;
   localparam int CHARS_W = 8 * MAX_TOKEN;

   localparam logic [2:0] ST_PENDING  = 3'd0;
   localparam logic [2:0] ST_AWAITING = 3'd1;
   localparam logic [2:0] ST_SUCCESS  = 3'd2;
   localparam logic [2:0] ST_UNKNOWN  = 3'd3;
   localparam logic [2:0] ST_DEFINED  = 3'd4;

   localparam logic MODE_DATA   = 1'b0;
   localparam logic MODE_DEFINE = 1'b1;

   typedef struct packed {
      logic         mode;
      logic [7:0]   data_byte;
      logic [2:0]   slot;
      logic [7:0]   def_code;
      logic [3:0]   token_length;
      logic [63:0]  token_chars;
      logic [4:0]   def_payload_length;
   } req_type;

   typedef struct packed {
      logic [2:0]   status;
      logic [7:0]   matched_code;
      logic [4:0]   payload_count;
      logic [7:0]   payload_byte;
      logic [3:0]   payload_index;
      logic         last;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic dispatch;
      logic scan;
      logic put_result;
      logic put_emit;
   } ctm_cmd_type;

   typedef struct packed {
      logic disp_to_scan;
      logic disp_to_emit;
      logic scan_done;
      logic scan_retry;
      logic scan_to_emit;
      logic out_free;
      logic emit_last;
   } ctm_sts_type;

endpackage

`default_nettype wire

[src/ctm_ctrl.sv]
// ---------------------------------------------------------------------------
// ctm_ctrl
// Sequencer of the command token matcher: takes one transaction, dispatches
// it, steps the table scan and drives result and payload output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ctm_ctrl
   import ctm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire ctm_sts_type sts,
   output ctm_cmd_type      cmd
);

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_DISPATCH = 5'b00010,
      S_SCAN     = 5'b00100,
      S_RESULT   = 5'b01000,
      S_EMIT     = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd.dispatch = 1'b1;
            if (sts.disp_to_emit) begin
               state_in = S_EMIT;
            end else if (sts.disp_to_scan) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_retry) begin
               state_in = S_DISPATCH;
            end else if (sts.scan_to_emit) begin
               state_in = S_EMIT;
            end else if (sts.scan_done) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (sts.out_free) begin
               cmd.put_result = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.put_emit = 1'b1;
               if (sts.emit_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[src/ctm_datapath.sv]
// ---------------------------------------------------------------------------
// ctm_datapath
// Definition table, word buffer, payload buffer, slot scan compare and the
// result output register of the command token matcher.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ctm_datapath
   import ctm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire req_type      req_data,
   input  wire logic         csr_wr_en,
   input  wire logic [3:0]   csr_wr_data,
   input  wire ctm_cmd_type  cmd,
   output ctm_sts_type       sts,
   input  wire logic         rsp_stall,
   output logic              rsp_valid,
   output rsp_type           rsp_data
);

   typedef enum logic [2:0] {
      PH_READY  = 3'b001,
      PH_DECODE = 3'b010,
      PH_AWAIT  = 3'b100
   } phase_type;

   req_type                item_ff;
   logic [ACT_W-1:0]       active_ff;
   phase_type              phase_ff, phase_in;
   logic [7:0]             word_chars_ff [MAX_TOKEN];
   logic [LEN_W-1:0]       word_len_ff, word_len_in;
   logic [SLOT_W-1:0]      matched_ff, matched_in;
   logic [PAY_W-1:0]       missing_ff, missing_in;
   logic [PAY_W-1:0]       fill_ff, fill_in;
   logic [7:0]             store_ff [PAYLOAD_MAX];
   logic [7:0]             tab_code_ff [MAX_DEFS];
   logic [LEN_W-1:0]       tab_len_ff [MAX_DEFS];
   logic [PAY_W-1:0]       tab_pl_ff [MAX_DEFS];
   logic [CHARS_W-1:0]     tab_chars_ff [MAX_DEFS];
   logic                   retry_ff, retry_in;
   logic [SCAN_W-1:0]      scan_idx_ff, scan_idx_in;
   logic [2:0]             res_status_ff, res_status_in;
   logic [PAY_W-1:0]       emit_idx_ff, emit_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   word_we;
   logic [LEN_W-1:0]       base_len;
   logic                   store_we;
   logic                   tab_we;
   logic [LEN_W-1:0]       len_sat;
   logic [PAY_W-1:0]       pl_sat;
   logic [PAY_W-1:0]       missing_dec;
   logic [SCAN_W-1:0]      scan_lim;
   logic                   scan_end;
   logic [SLOT_W-1:0]      cur_slot;
   logic                   chars_eq;
   logic                   hit;
   logic                   full;
   logic                   emit_last;
   logic [7:0]             emit_byte;

   // scan compare on the slot under the scan pointer
   always_comb begin
      scan_lim = (active_ff > ACT_W'(MAX_DEFS)) ? SCAN_W'(MAX_DEFS) : SCAN_W'(active_ff);
      scan_end = (scan_idx_ff >= scan_lim);
      cur_slot = scan_idx_ff[SLOT_W-1:0];
      chars_eq = 1'b1;
      for (int c = 0; c < MAX_TOKEN; c++) begin
         if ((LEN_W'(c) < word_len_ff) &&
             (tab_chars_ff[cur_slot][8*c +: 8] != word_chars_ff[c])) begin
            chars_eq = 1'b0;
         end
      end
      hit  = !scan_end && (tab_len_ff[cur_slot] >= word_len_ff) && chars_eq;
      full = (tab_len_ff[cur_slot] == word_len_ff);
   end

   always_comb begin
      len_sat = (item_ff.token_length > LEN_W'(MAX_TOKEN)) ?
                LEN_W'(MAX_TOKEN) : item_ff.token_length;
      pl_sat  = (item_ff.def_payload_length > PAY_W'(PAYLOAD_MAX)) ?
                PAY_W'(PAYLOAD_MAX) : item_ff.def_payload_length;
      missing_dec = (missing_ff != '0) ? (missing_ff - PAY_W'(1)) : '0;
      base_len    = (phase_ff == PH_DECODE) ? word_len_ff : '0;
      emit_last   = (fill_ff == '0) || ((emit_idx_ff + PAY_W'(1)) == fill_ff);
      emit_byte   = (fill_ff == '0) ? 8'd0 : store_ff[emit_idx_ff[IDX_W-1:0]];
   end

   always_comb begin
      phase_in      = phase_ff;
      word_len_in   = word_len_ff;
      matched_in    = matched_ff;
      missing_in    = missing_ff;
      fill_in       = fill_ff;
      retry_in      = retry_ff;
      scan_idx_in   = scan_idx_ff;
      res_status_in = res_status_ff;
      emit_idx_in   = emit_idx_ff;
      word_we       = 1'b0;
      store_we      = 1'b0;
      tab_we        = 1'b0;

      if (cmd.dispatch) begin
         emit_idx_in = '0;
         if (item_ff.mode == MODE_DEFINE) begin
            tab_we        = 1'b1;
            res_status_in = ST_DEFINED;
         end else if (phase_ff == PH_AWAIT) begin
            if (fill_ff < PAY_W'(PAYLOAD_MAX)) begin
               store_we = 1'b1;
               fill_in  = fill_ff + PAY_W'(1);
            end
            missing_in = missing_dec;
            if (missing_dec == '0) begin
               phase_in = PH_READY;
            end else begin
               res_status_in = ST_AWAITING;
            end
         end else begin
            if (phase_ff != PH_DECODE) begin
               missing_in = '0;
               fill_in    = '0;
               phase_in   = PH_DECODE;
            end
            if (base_len < LEN_W'(MAX_TOKEN)) begin
               word_we     = 1'b1;
               word_len_in = base_len + LEN_W'(1);
            end else begin
               word_len_in = base_len;
            end
            scan_idx_in = '0;
         end
      end

      if (cmd.scan) begin
         emit_idx_in = '0;
         if (hit) begin
            retry_in = 1'b1;
            if (full) begin
               matched_in = cur_slot;
               missing_in = tab_pl_ff[cur_slot];
               fill_in    = '0;
               if (tab_pl_ff[cur_slot] == '0) begin
                  phase_in = PH_READY;
               end else begin
                  phase_in      = PH_AWAIT;
                  res_status_in = ST_AWAITING;
               end
            end else begin
               res_status_in = ST_PENDING;
            end
         end else if (scan_end) begin
            phase_in = PH_READY;
            if (retry_ff) begin
               retry_in = 1'b0;
            end else begin
               res_status_in = ST_UNKNOWN;
            end
         end else begin
            scan_idx_in = scan_idx_ff + SCAN_W'(1);
         end
      end

      if (cmd.put_emit) begin
         emit_idx_in = emit_idx_ff + PAY_W'(1);
      end
   end

   always_comb begin
      sts.disp_to_scan = (item_ff.mode == MODE_DATA) && (phase_ff != PH_AWAIT);
      sts.disp_to_emit = (item_ff.mode == MODE_DATA) && (phase_ff == PH_AWAIT) &&
                         (missing_dec == '0);
      sts.scan_done    = hit || scan_end;
      sts.scan_retry   = !hit && scan_end && retry_ff;
      sts.scan_to_emit = hit && full && (tab_pl_ff[cur_slot] == '0);
      sts.out_free     = !rsp_valid_ff || !rsp_stall;
      sts.emit_last    = emit_last;
   end

   // output register: hold while stalled, load on a put command
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.put_result) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         rsp_in.status = res_status_ff;
         rsp_in.last   = 1'b1;
      end else if (cmd.put_emit) begin
         rsp_valid_in         = 1'b1;
         rsp_in.status        = ST_SUCCESS;
         rsp_in.matched_code  = tab_code_ff[matched_ff];
         rsp_in.payload_count = fill_ff;
         rsp_in.payload_byte  = emit_byte;
         rsp_in.payload_index = emit_idx_ff[IDX_W-1:0];
         rsp_in.last          = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= '0;
         phase_ff      <= PH_READY;
         word_len_ff   <= '0;
         matched_ff    <= '0;
         missing_ff    <= '0;
         fill_ff       <= '0;
         retry_ff      <= 1'b1;
         scan_idx_ff   <= '0;
         emit_idx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < MAX_DEFS; i++) begin
            tab_len_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
         phase_ff     <= phase_in;
         word_len_ff  <= word_len_in;
         matched_ff   <= matched_in;
         missing_ff   <= missing_in;
         fill_ff      <= fill_in;
         retry_ff     <= retry_in;
         scan_idx_ff  <= scan_idx_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (tab_we) begin
            tab_len_ff[item_ff.slot[SLOT_W-1:0]] <= len_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
      if (word_we) begin
         word_chars_ff[base_len[$clog2(MAX_TOKEN)-1:0]] <= item_ff.data_byte;
      end
      if (store_we) begin
         store_ff[fill_ff[IDX_W-1:0]] <= item_ff.data_byte;
      end
      if (tab_we) begin
         tab_code_ff[item_ff.slot[SLOT_W-1:0]]  <= item_ff.def_code;
         tab_pl_ff[item_ff.slot[SLOT_W-1:0]]    <= pl_sat;
         tab_chars_ff[item_ff.slot[SLOT_W-1:0]] <= item_ff.token_chars;
      end
      res_status_ff <= res_status_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[src/command_token_matcher.sv]
// ---------------------------------------------------------------------------
// command_token_matcher
// Byte-stream command recognizer: a definition table of token slots, word
// matching by a slot-by-slot scan, payload collection and payload output.
//
//   channel  | ports                          | direction
//   ---------+--------------------------------+-----------
//   request  | req_valid, req_stall, req_data | in
//   result   | rsp_valid, rsp_stall, rsp_data | out
//   config   | csr_wr_en, csr_wr_data         | in
//
// Definition and payload bytes pass accept, dispatch and result; a word byte
// adds a scan step per slot examined, one more on a miss, and a retry repeats
// dispatch and scan. Completion emits one result a cycle while rsp_stall is
// low, one per payload byte or a lone one with no payload, instead of the
// result. Synchronous reset; transactions are taken from the next cycle.
// rsp_stall holds the output register and the sequencer behind it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module command_token_matcher
   import ctm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_wr_en,
   input  wire logic [3:0]  csr_wr_data
);

   ctm_cmd_type cmd;
   ctm_sts_type sts;

   ctm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ctm_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

[src/ctm_checker.sv]
// ---------------------------------------------------------------------------
// ctm_checker
// Port-level checks of the command token matcher, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ctm_checker
   import ctm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire rsp_type     rsp_data
);

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("transaction taken while previous one is in progress");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_only_success_multi: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_SUCCESS) |-> rsp_data.last)
      else $error("non-success result without last");

   a_payload_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=>
         rsp_valid && (rsp_data.status == ST_SUCCESS) &&
         (rsp_data.matched_code == $past(rsp_data.matched_code)) &&
         (rsp_data.payload_index == 4'($past(rsp_data.payload_index) + 4'd1)))
      else $error("payload burst broken");

endmodule

bind command_token_matcher ctm_checker u_ctm_checker (.*);

`default_nettype wire
